// File: hdl/circular_deque_engine_top_defines.svh
// assertion macros for the circular deque engine
// used by the checker module; no other dependencies
`ifndef CIRCULAR_DEQUE_ENGINE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_ENGINE_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define CDE_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CDE_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/cde_pkg.sv
// shared types and constants for the circular deque engine
// no dependencies
`timescale 1ns / 1ps

package cde_pkg;

  // field widths of the words on both channels
  localparam int ACT_W  = 3;
  localparam int DATA_W = 8;
  localparam int AMT_W  = 8;
  localparam int CNT_W  = 7;
  // move counter holds up to the magnitude of the rotate amount
  localparam int MOVE_W = 8;

  localparam int MAX_SLOTS_DEF = 64;
  localparam logic [CNT_W-1:0] RING_SIZE_RST = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_ROTATE     = 3'd4,
    ACT_REVERSE    = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_MV_RD,
    ST_MV_WR,
    ST_RV_RDA,
    ST_RV_RDB,
    ST_RV_WRA,
    ST_RV_WRB,
    ST_DONE
  } state_t;

endpackage

// File: hdl/cde_if.sv
// channel interfaces for the circular deque engine (request and result words)
// depends on cde_pkg
`timescale 1ns / 1ps

interface cde_in_if import cde_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [DATA_W-1:0]       push_value;
  logic signed [AMT_W-1:0] rotate_amount;

  modport source (output valid, action, push_value, rotate_amount, input ready);
  modport sink   (input valid, action, push_value, rotate_amount, output ready);
endinterface

interface cde_out_if import cde_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              success;
  logic [DATA_W-1:0] popped_value;
  logic [CNT_W-1:0]  item_count;

  modport source (output valid, success, popped_value, item_count, input ready);
  modport sink   (input valid, success, popped_value, item_count, output ready);
endinterface

// File: hdl/cde_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/circular_deque_engine_top.sv
// Circular deque engine: byte deque on a one-port-read, one-port-write ring memory.
// Result register: push, failed pop, unknown action, trivial rotate or reverse load it
// straight from the accepted word; pop loads it after the memory read; rotate moves |amount|
// bytes, one read and one write per moved byte; reverse swaps floor(count/2) pairs, two reads,
// two writes a swap. One word in flight at a time.
// Reset empties the deque and sets the ring size to 64; memory contents are undefined.
`timescale 1ns / 1ps

module circular_deque_engine_top import cde_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  cde_in_if.sink           in_ch,
  cde_out_if.source        out_ch
);

  localparam int IW = $clog2(MAX_SLOTS);

  // control and pointer registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   ring_size;
  logic [IW-1:0]      head, head_next;
  logic [IW-1:0]      tail, tail_next;
  logic [CNT_W-1:0]   held, held_next;
  logic [MOVE_W-1:0]  move_left, move_left_next;
  logic               move_back, move_back_next;
  logic [IW-1:0]      lo, lo_next;
  logic [IW-1:0]      hi, hi_next;
  logic [DATA_W-1:0]  swap_byte, swap_byte_next;

  // result register
  logic               o_valid;
  logic               o_success;
  logic [DATA_W-1:0]  o_popped;
  logic [CNT_W-1:0]   o_count;

  // result load request
  logic               res_load;
  logic               res_success;
  logic [DATA_W-1:0]  res_popped;

  // memory port
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]   ring;
  logic [IW-1:0]      ring_last;
  logic               out_free;
  logic               accept;
  logic               last_move;
  logic [MOVE_W-1:0]  amount_mag;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p,
                                            input logic [IW-1:0] last);
    return (p == last) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p,
                                            input logic [IW-1:0] last);
    return (p == '0) ? last : p - 1'b1;
  endfunction

  // effective ring length, clamped to 1 .. MAX_SLOTS
  always_comb begin
    if (ring_size == '0) begin
      ring = CNT_W'(1);
    end else if (int'(ring_size) > MAX_SLOTS) begin
      ring = CNT_W'(MAX_SLOTS);
    end else begin
      ring = ring_size;
    end
  end

  assign ring_last  = IW'(ring - 1'b1);
  assign out_free   = !o_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign accept     = in_ch.valid && in_ch.ready;
  assign last_move  = (move_left == MOVE_W'(1));
  assign amount_mag = in_ch.rotate_amount[AMT_W-1] ?
                      MOVE_W'(~in_ch.rotate_amount + 1'b1) :
                      MOVE_W'(in_ch.rotate_amount);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_ch.action))
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (held != '0) state_next = ST_POP;
            end
            ACT_ROTATE: begin
              if (held != '0 && in_ch.rotate_amount != '0) state_next = ST_MV_RD;
            end
            ACT_REVERSE: begin
              if (held > CNT_W'(1)) state_next = ST_RV_RDA;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_POP:    if (out_free) state_next = ST_IDLE;
      ST_MV_RD:  state_next = ST_MV_WR;
      ST_MV_WR:  state_next = last_move ? ST_DONE : ST_MV_RD;
      ST_RV_RDA: state_next = ST_RV_RDB;
      ST_RV_RDB: state_next = ST_RV_WRA;
      ST_RV_WRA: state_next = ST_RV_WRB;
      ST_RV_WRB: state_next = last_move ? ST_DONE : ST_RV_RDA;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    held_next      = held;
    move_left_next = move_left;
    move_back_next = move_back;
    lo_next        = lo;
    hi_next        = hi;
    swap_byte_next = swap_byte;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    res_load       = 1'b0;
    res_success    = 1'b0;
    res_popped     = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_ch.action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              res_load = 1'b1;
              if (held == '0) begin
                // empty queue restarts at slot 0
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = in_ch.push_value;
                head_next   = '0;
                tail_next   = '0;
                held_next   = CNT_W'(1);
                res_success = 1'b1;
              end else if (held < ring) begin
                ram_we    = 1'b1;
                ram_wdata = in_ch.push_value;
                if (in_ch.action == ACT_PUSH_FRONT) begin
                  head_next = ptr_dec(head, ring_last);
                  ram_waddr = ptr_dec(head, ring_last);
                end else begin
                  tail_next = ptr_inc(tail, ring_last);
                  ram_waddr = ptr_inc(tail, ring_last);
                end
                held_next   = held + 1'b1;
                res_success = 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (held != '0) begin
                ram_re    = 1'b1;
                ram_raddr = head;
                head_next = ptr_inc(head, ring_last);
                held_next = held - 1'b1;
              end else begin
                res_load = 1'b1;
              end
            end
            ACT_POP_BACK: begin
              if (held != '0) begin
                ram_re    = 1'b1;
                ram_raddr = tail;
                tail_next = ptr_dec(tail, ring_last);
                held_next = held - 1'b1;
              end else begin
                res_load = 1'b1;
              end
            end
            ACT_ROTATE: begin
              // rotate by amount moves, one byte end to end per move
              move_left_next = amount_mag;
              move_back_next = in_ch.rotate_amount[AMT_W-1];
              if (held == '0 || in_ch.rotate_amount == '0) begin
                res_load    = 1'b1;
                res_success = 1'b1;
              end
            end
            ACT_REVERSE: begin
              lo_next        = head;
              hi_next        = tail;
              move_left_next = MOVE_W'(held >> 1);
              if (held <= CNT_W'(1)) begin
                res_load    = 1'b1;
                res_success = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_success = 1'b1;
          res_popped  = ram_rdata;
        end
      end
      ST_MV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = move_back ? tail : head;
      end
      ST_MV_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata;
        move_left_next = move_left - 1'b1;
        if (move_back) begin
          ram_waddr = ptr_dec(head, ring_last);
          head_next = ptr_dec(head, ring_last);
          tail_next = ptr_dec(tail, ring_last);
        end else begin
          ram_waddr = ptr_inc(tail, ring_last);
          head_next = ptr_inc(head, ring_last);
          tail_next = ptr_inc(tail, ring_last);
        end
      end
      ST_RV_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = lo;
      end
      ST_RV_RDB: begin
        ram_re         = 1'b1;
        ram_raddr      = hi;
        swap_byte_next = ram_rdata;
      end
      ST_RV_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      ST_RV_WRB: begin
        ram_we         = 1'b1;
        ram_waddr      = hi;
        ram_wdata      = swap_byte;
        lo_next        = ptr_inc(lo, ring_last);
        hi_next        = ptr_dec(hi, ring_last);
        move_left_next = move_left - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_success = 1'b1;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // control registers; a ring size write empties the deque
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ring_size <= RING_SIZE_RST;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      o_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        ring_size <= cfg_wdata;
        head      <= '0;
        tail      <= '0;
        held      <= '0;
      end else begin
        head <= head_next;
        tail <= tail_next;
        held <= held_next;
      end
      if (res_load) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    move_left <= move_left_next;
    move_back <= move_back_next;
    lo        <= lo_next;
    hi        <= hi_next;
    swap_byte <= swap_byte_next;
    if (res_load) begin
      o_success <= res_success;
      o_popped  <= res_popped;
      o_count   <= held_next;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.success      = o_success;
  assign out_ch.popped_value = o_popped;
  assign out_ch.item_count   = o_count;

  // byte store
  cde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: hdl/cde_checker.sv
// port-level checks on the result channel of the circular deque engine
// depends on cde_pkg and circular_deque_engine_top_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "circular_deque_engine_top_defines.svh"

module cde_checker import cde_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              success,
  input logic [DATA_W-1:0] popped_value,
  input logic [CNT_W-1:0]  item_count
);

  // a stalled result word holds
  `CDE_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(success) && $stable(popped_value) && $stable(item_count), "result word changed while stalled")

  // a failed action never reports a popped byte
  `CDE_ASSERT_RST(a_fail_no_byte, clk, rst, out_valid && !success |-> popped_value == '0, "failed action returned a byte")

  // no result word right after reset
  `CDE_ASSERT(a_reset_clear, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind circular_deque_engine_top cde_checker u_cde_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .success      (out_ch.success),
  .popped_value (out_ch.popped_value),
  .item_count   (out_ch.item_count)
);
